/* hw/rtl/assert_macros.svh */
// Assertion macros used by printf_format_stream_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared constants and types of the printf format stream unit.
// ----------------------------------------------------------------------------
package pfs_pkg;
  localparam int unsigned CharW = 8;
  localparam int unsigned ArgW  = 64;
  localparam int unsigned DigMax = 23;
  localparam int unsigned AddrW = 2;

  localparam logic [CharW-1:0] ChPct = 8'h25;
  localparam logic [CharW-1:0] ChH   = 8'h68;
  localparam logic [CharW-1:0] ChL   = 8'h6c;
  localparam logic [CharW-1:0] ChC   = 8'h63;
  localparam logic [CharW-1:0] ChD   = 8'h64;
  localparam logic [CharW-1:0] ChI   = 8'h69;
  localparam logic [CharW-1:0] ChU   = 8'h75;
  localparam logic [CharW-1:0] ChX   = 8'h78;
  localparam logic [CharW-1:0] ChXU  = 8'h58;
  localparam logic [CharW-1:0] ChP   = 8'h70;
  localparam logic [CharW-1:0] ChO   = 8'h6f;
  localparam logic [CharW-1:0] ChMinus = 8'h2d;

  localparam logic [AddrW-1:0] RegLongIsWide = 2'd0;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2
  } radix_t;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
    digit_char = (d < 4'd10) ? (8'h30 + {4'd0, d}) : (8'h57 + {4'd0, d});
  endfunction
endpackage

/* hw/rtl/printf_format_stream_unit.sv */
// ----------------------------------------------------------------------------
// printf_format_stream_unit
// Streaming printf formatter: passes text, converts integer and character arguments.
// ----------------------------------------------------------------------------
//  channel | direction | ports
//  in      | sink      | in_valid, in_ready, in_fmt_char, in_arg_value
//  out     | source    | out_valid, out_ready, out_out_char, out_last, out_arg_taken
//  cfg     | APB write | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata
//
// A text character is accepted and held in the output register; a modifier
// only updates the parse state. A decimal conversion divides the magnitude
// by ten one quotient bit per cycle and then stores one digit, for each
// digit in turn. Hex and octal digits are taken directly by shifting.
// Digits are kept in a small buffer and played out most significant first,
// after the sign of a negative number, one transfer per cycle while
// out_ready is high. Reset is synchronous and active low; no clearing pass
// is needed. A stall on the output simply holds the current character; no
// new item is taken until the last one is delivered.
module printf_format_stream_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pfs_pkg::CharW-1:0]    in_fmt_char,
  input  logic [pfs_pkg::ArgW-1:0]     in_arg_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pfs_pkg::CharW-1:0]    out_out_char,
  output logic                         out_last,
  output logic                         out_arg_taken,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [pfs_pkg::AddrW-1:0]    cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);
  import pfs_pkg::*;
`include "assert_macros.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_DIGIT, S_EMIT_SIGN, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    P_TEXT, P_PCT, P_H, P_L, P_DONE
  } pstate_t;

  typedef enum logic [2:0] {
    LEN_DEF, LEN_HH, LEN_H, LEN_L, LEN_LL
  } lmod_t;

  state_t             state_r;
  pstate_t            pstate_r;
  lmod_t              lmod_r;
  logic               long_is_wide_r;
  logic [ArgW-1:0]    mag_r;    // remaining magnitude / dividend (quotient bits)
  logic [3:0]         rem_r;
  logic [6:0]         bit_r;
  logic               wide_r;
  radix_t             radix_r;
  logic               neg_r;
  logic [3:0]         dig_r [DigMax];
  logic [4:0]         cnt_r;
  logic               oval_r;
  logic [CharW-1:0]   ochar_r;
  logic               olast_r;
  logic               otaken_r;

  logic out_free;
  assign out_free = !oval_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign out_valid = oval_r;
  assign out_out_char = ochar_r;
  assign out_last = olast_r;
  assign out_arg_taken = otaken_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, long_is_wide_r};

  // Decode of a conversion character in the current parse context.
  logic is_mod, conv_num, conv_c, conv_pct, sgn, wide;
  radix_t rad;
  logic [ArgW-1:0] arg_m, mag_in;
  always_comb begin
    is_mod = 1'b0;
    unique case (pstate_r)
      P_PCT:   is_mod = (in_fmt_char == ChH) || (in_fmt_char == ChL);
      P_H:     is_mod = (in_fmt_char == ChH);
      P_L:     is_mod = (in_fmt_char == ChL);
      default: is_mod = 1'b0;
    endcase
    conv_c = (in_fmt_char == ChC);
    conv_pct = (in_fmt_char == ChPct);
    sgn = (in_fmt_char == ChD) || (in_fmt_char == ChI);
    conv_num = sgn || (in_fmt_char == ChU) || (in_fmt_char == ChX) ||
               (in_fmt_char == ChXU) || (in_fmt_char == ChP) || (in_fmt_char == ChO);
    rad = RADIX_DEC;
    if ((in_fmt_char == ChX) || (in_fmt_char == ChXU) || (in_fmt_char == ChP))
      rad = RADIX_HEX;
    else if (in_fmt_char == ChO)
      rad = RADIX_OCT;
    wide = (lmod_r == LEN_LL) || ((lmod_r == LEN_L) && long_is_wide_r);
    arg_m = wide ? in_arg_value : {32'd0, in_arg_value[31:0]};
    if (sgn && !wide && in_arg_value[31])
      arg_m = {32'hffffffff, in_arg_value[31:0]};
    mag_in = (sgn && arg_m[ArgW-1]) ? (~arg_m + 64'd1) : arg_m;
  end

  // The output register is loaded by a text character, a %c or %% conversion,
  // the sign of a negative number and each digit as it is played out.
  logic load_o;
  assign load_o = ((state_r == S_IDLE) && in_valid && in_ready &&
                   ((pstate_r == P_TEXT) ? (in_fmt_char != ChPct) :
                                           (!is_mod && (conv_c || conv_pct)))) ||
                  (((state_r == S_EMIT_SIGN) || (state_r == S_EMIT)) && out_free);

  // One restoring-division step by ten.
  logic [4:0] trial;
  assign trial = {rem_r, mag_r[ArgW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pstate_r <= P_TEXT;
      lmod_r <= LEN_DEF;
      long_is_wide_r <= 1'b1;
      oval_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == RegLongIsWide))
        long_is_wide_r <= cfg_pwdata[0];
      if (load_o)
        oval_r <= 1'b1;
      else if (out_ready)
        oval_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            if (pstate_r == P_TEXT) begin
              if (in_fmt_char == ChPct) begin
                pstate_r <= P_PCT;
              end else begin
                ochar_r <= in_fmt_char;
                olast_r <= 1'b1; otaken_r <= 1'b0;
              end
            end else if (is_mod) begin
              if (pstate_r == P_PCT) begin
                pstate_r <= (in_fmt_char == ChH) ? P_H : P_L;
                lmod_r <= (in_fmt_char == ChH) ? LEN_H : LEN_L;
              end else begin
                pstate_r <= P_DONE;
                lmod_r <= (pstate_r == P_H) ? LEN_HH : LEN_LL;
              end
            end else begin
              pstate_r <= P_TEXT;
              lmod_r <= LEN_DEF;
              if (conv_c || conv_pct) begin
                ochar_r <= conv_c ? in_arg_value[7:0] : ChPct;
                olast_r <= 1'b1; otaken_r <= conv_c;
              end else if (conv_num) begin
                mag_r <= wide ? mag_in : {mag_in[31:0], 32'd0};
                wide_r <= wide; radix_r <= rad;
                neg_r <= sgn && arg_m[ArgW-1];
                rem_r <= '0; cnt_r <= '0;
                bit_r <= wide ? 7'd64 : 7'd32;
                state_r <= (rad == RADIX_DEC) ? S_DIV : S_DIGIT;
              end
            end
          end
        end
        S_DIV: begin
          if (trial >= 5'd10) begin
            rem_r <= 4'(trial - 5'd10);
            mag_r <= {mag_r[ArgW-2:0], 1'b1};
          end else begin
            rem_r <= trial[3:0];
            mag_r <= {mag_r[ArgW-2:0], 1'b0};
          end
          bit_r <= bit_r - 7'd1;
          if (bit_r == 7'd1) state_r <= S_DIGIT;
        end
        S_DIGIT: begin
          // Store one digit; in decimal mode mag_r now holds the quotient.
          logic [ArgW-1:0] q;
          logic [3:0] d;
          if (radix_r == RADIX_DEC) begin
            d = rem_r;
            q = wide_r ? mag_r : {32'd0, mag_r[31:0]};
          end else if (radix_r == RADIX_HEX) begin
            q = wide_r ? mag_r : {32'd0, mag_r[ArgW-1:32]};
            d = q[3:0]; q = q >> 4;
          end else begin
            q = wide_r ? mag_r : {32'd0, mag_r[ArgW-1:32]};
            d = {1'b0, q[2:0]}; q = q >> 3;
          end
          dig_r[cnt_r] <= d;
          cnt_r <= cnt_r + 5'd1;
          rem_r <= '0;
          bit_r <= wide_r ? 7'd64 : 7'd32;
          mag_r <= wide_r ? q : {q[31:0], 32'd0};
          if (q == '0)
            state_r <= neg_r ? S_EMIT_SIGN : S_EMIT;
          else if (radix_r == RADIX_DEC)
            state_r <= S_DIV;
        end
        S_EMIT_SIGN: begin
          if (out_free) begin
            ochar_r <= ChMinus;
            olast_r <= 1'b0; otaken_r <= 1'b0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            ochar_r <= digit_char(dig_r[cnt_r - 5'd1]);
            olast_r <= (cnt_r == 5'd1);
            otaken_r <= (cnt_r == 5'd1);
            cnt_r <= cnt_r - 5'd1;
            if (cnt_r == 5'd1) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_ready_idle, clk, rst_n, in_ready, state_r == S_IDLE)
  `ASSERT_IMPLIES(a_taken_last, clk, rst_n, out_valid && out_arg_taken, out_last)
  `ASSERT_IMPLIES(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= 5'(DigMax))
  `ASSERT_NEXT(a_emit_hold, clk, rst_n, out_valid && !out_ready,
               out_valid && $stable(out_out_char))
endmodule
